// ===== hw/rtl/pfss_pkg.sv =====
// Package for the Pareto front selector: record type and sequencer states.
// No dependencies.
package pfss_pkg;

	typedef struct packed {
		logic [31:0] score;
		logic [31:0] cost;
		logic [15:0] buckets;
		logic [31:0] rebalance;
		logic [15:0] probe;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DOM_RD,
		ST_DOM_CMP,
		ST_SEL_RD,
		ST_SEL_CMP,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/pareto_front_select_sort.sv =====
// Pareto front selector and sorter, top level.
// Depends on pfss_pkg.
//
// Trials load at one transaction per cycle until the one marked tlast. The block then
// drops ready and runs a sequencer around one shared compare unit that reads the
// record memory: a dominance pass of N*N compares, then a selection sort that
// picks the next front member in N compares per emitted record, where N is the
// number of stored trials. Ready returns only after the last front member has
// been taken, so m_tready held low delays it. Trials beyond MAX_TRIALS are
// dropped and every result of that set carries the overflow flag.
module pareto_front_select_sort import pfss_pkg::*; #(
	parameter int MAX_TRIALS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// score[31:0], cost[63:32], bucket_count[79:64], rebalance_period[111:80],
	// probe_rad[127:112]
	input  logic [127:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// front_score[31:0], front_cost[63:32], front_buckets[79:64],
	// front_rebalance[111:80], front_probe[127:112]
	output logic [127:0] m_tdata,
	output logic         m_tlast,
	// overflowed
	output logic         m_tuser
);

	localparam int AW = $clog2(MAX_TRIALS);
	localparam int CW = $clog2(MAX_TRIALS + 1);

	rec_t              mem_q [MAX_TRIALS];
	rec_t              rd_q;
	rec_t              ref_q;
	logic [AW-1:0]     rd_addr;
	logic [MAX_TRIALS-1:0] beaten_q;
	logic [MAX_TRIALS-1:0] done_q;
	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [CW-1:0]     i_q, j_q;
	logic [AW-1:0]     best_q;
	logic              have_q;
	logic [CW-1:0]     left_q;
	state_t            state_q, state_d;

	rec_t in_rec;
	logic s_fire, m_fire;
	logic a_dom, a_bef;
	logic [31:0] sa, sb;

	assign in_rec.score     = s_tdata[31:0];
	assign in_rec.cost      = s_tdata[63:32];
	assign in_rec.buckets   = s_tdata[79:64];
	assign in_rec.rebalance = s_tdata[111:80];
	assign in_rec.probe     = s_tdata[127:112];

	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;

	// shared compare unit: rd_q against ref_q
	always_comb begin
		sa = rd_q.score ^ 32'h8000_0000;
		sb = ref_q.score ^ 32'h8000_0000;
		a_dom = (sa >= sb) && (rd_q.cost <= ref_q.cost) &&
			((sa > sb) || (rd_q.cost < ref_q.cost));
		if (sa != sb)
			a_bef = sa > sb;
		else if (rd_q.cost != ref_q.cost)
			a_bef = rd_q.cost < ref_q.cost;
		else if (rd_q.buckets != ref_q.buckets)
			a_bef = rd_q.buckets < ref_q.buckets;
		else if (rd_q.rebalance != ref_q.rebalance)
			a_bef = rd_q.rebalance < ref_q.rebalance;
		else
			a_bef = rd_q.probe < ref_q.probe;
	end

	always_comb begin
		unique case (state_q)
			ST_DOM_RD, ST_DOM_CMP, ST_SEL_RD, ST_SEL_CMP: rd_addr = j_q[AW-1:0];
			default:                                      rd_addr = best_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_fire && count_q < CW'(MAX_TRIALS))
			mem_q[count_q[AW-1:0]] <= in_rec;
		rd_q <= mem_q[rd_addr];
		if (state_q == ST_DOM_RD && j_q == '0)
			ref_q <= mem_q[i_q[AW-1:0]];
		else if (state_q == ST_SEL_CMP && !done_q[j_q[AW-1:0]] &&
			!beaten_q[j_q[AW-1:0]] && (!have_q || a_bef))
			ref_q <= rd_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:    if (s_fire && s_tlast) state_d = ST_DOM_RD;
			ST_DOM_RD:  state_d = ST_DOM_CMP;
			ST_DOM_CMP: begin
				if (j_q + 1'b1 < count_q)
					state_d = ST_DOM_RD;
				else if (i_q + 1'b1 < count_q)
					state_d = ST_DOM_RD;
				else
					state_d = ST_SEL_RD;
			end
			ST_SEL_RD:  state_d = ST_SEL_CMP;
			ST_SEL_CMP: state_d = (j_q + 1'b1 < count_q) ? ST_SEL_RD : ST_EMIT_RD;
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT:    if (m_fire) state_d = (left_q == CW'(1)) ? ST_LOAD : ST_SEL_RD;
			default:    state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = state_q == ST_LOAD;
		m_tvalid = state_q == ST_EMIT;
		m_tdata  = {rd_q.probe, rd_q.rebalance, rd_q.buckets, rd_q.cost, rd_q.score};
		m_tlast  = left_q == CW'(1);
		m_tuser  = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			best_q   <= '0;
			have_q   <= 1'b0;
			left_q   <= '0;
			beaten_q <= '0;
			done_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (s_fire) begin
						if (count_q < CW'(MAX_TRIALS))
							count_q <= count_q + 1'b1;
						else
							ovf_q <= 1'b1;
					end
					i_q      <= '0;
					j_q      <= '0;
					beaten_q <= '0;
					done_q   <= '0;
					have_q   <= 1'b0;
					left_q   <= '0;
				end
				ST_DOM_RD: ;
				ST_DOM_CMP: begin
					if (a_dom)
						beaten_q[i_q[AW-1:0]] <= 1'b1;
					if (j_q + 1'b1 < count_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (!beaten_q[i_q[AW-1:0]] && !a_dom)
							left_q <= left_q + 1'b1;
					end
				end
				ST_SEL_RD: ;
				ST_SEL_CMP: begin
					if (!done_q[j_q[AW-1:0]] && !beaten_q[j_q[AW-1:0]] &&
						(!have_q || a_bef)) begin
						best_q <= j_q[AW-1:0];
						have_q <= 1'b1;
					end
					j_q <= (j_q + 1'b1 < count_q) ? j_q + 1'b1 : '0;
				end
				ST_EMIT_RD: done_q[best_q] <= 1'b1;
				ST_EMIT: begin
					if (m_fire) begin
						left_q <= left_q - 1'b1;
						have_q <= 1'b0;
						j_q    <= '0;
						if (left_q == CW'(1)) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
